// File: src/srht_pkg.sv
// Shared widths and stage types for the segment / rectangle hit test.
// No dependencies; imported by srht_prep, srht_cross and the top level.
package srht_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;

    // Stage 1 result: coordinate offsets from the segment start.
    typedef struct packed {
        logic [DIFF_W-1:0] ax1;  // box_first_x  - start x
        logic [DIFF_W-1:0] ax2;  // box_second_x - start x
        logic [DIFF_W-1:0] by1;  // box_first_y  - start y
        logic [DIFF_W-1:0] by2;  // box_second_y - start y
        logic [DIFF_W-1:0] dx;   // end x - start x
        logic [DIFF_W-1:0] dy;   // end y - start y
        logic              sep;  // segment and box apart on the x or y axis
    } t_prep;

    // Stage 2 result: the four partial products of the corner cross products.
    typedef struct packed {
        logic [PROD_W-1:0] a1;   // ax1 * dy
        logic [PROD_W-1:0] a2;   // ax2 * dy
        logic [PROD_W-1:0] b1;   // by1 * dx
        logic [PROD_W-1:0] b2;   // by2 * dx
        logic              sep;
    } t_prod;

endpackage

// File: src/srht_prep.sv
// Stage 1 of the hit test: offsets from the segment start and axis separation.
// Depends on srht_pkg.
module srht_prep
    import srht_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  logic [COORD_BITS-1:0] i_sx,
    input  logic [COORD_BITS-1:0] i_sy,
    input  logic [COORD_BITS-1:0] i_ex,
    input  logic [COORD_BITS-1:0] i_ey,
    input  logic [COORD_BITS-1:0] i_x1,
    input  logic [COORD_BITS-1:0] i_y1,
    input  logic [COORD_BITS-1:0] i_x2,
    input  logic [COORD_BITS-1:0] i_y2,
    output logic                  o_vld,
    output t_prep                 o_prep
);

    logic  r_vld;
    t_prep r_prep;
    t_prep n_prep;

    function automatic logic [DIFF_W-1:0] sdiff(input logic [COORD_BITS-1:0] a,
                                                input logic [COORD_BITS-1:0] b);
        sdiff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    endfunction

    function automatic logic lt(input logic [COORD_BITS-1:0] a,
                                input logic [COORD_BITS-1:0] b);
        lt = $signed(a) < $signed(b);
    endfunction

    always_comb begin
        logic below_x, above_x, below_y, above_y;
        // both endpoints beyond the same side of the box on one axis
        below_x = lt(i_sx, i_x1) && lt(i_sx, i_x2) && lt(i_ex, i_x1) && lt(i_ex, i_x2);
        above_x = lt(i_x1, i_sx) && lt(i_x2, i_sx) && lt(i_x1, i_ex) && lt(i_x2, i_ex);
        below_y = lt(i_sy, i_y1) && lt(i_sy, i_y2) && lt(i_ey, i_y1) && lt(i_ey, i_y2);
        above_y = lt(i_y1, i_sy) && lt(i_y2, i_sy) && lt(i_y1, i_ey) && lt(i_y2, i_ey);
        n_prep.ax1 = sdiff(i_x1, i_sx);
        n_prep.ax2 = sdiff(i_x2, i_sx);
        n_prep.by1 = sdiff(i_y1, i_sy);
        n_prep.by2 = sdiff(i_y2, i_sy);
        n_prep.dx  = sdiff(i_ex, i_sx);
        n_prep.dy  = sdiff(i_ey, i_sy);
        n_prep.sep = below_x || above_x || below_y || above_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_prep <= n_prep;
    end

    assign o_vld  = r_vld;
    assign o_prep = r_prep;

endmodule

// File: src/srht_cross.sv
// Stages 2 and 3: corner cross products against the segment line, then the
// separating-line decision. Depends on srht_pkg.
module srht_cross
    import srht_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_prep i_prep,
    output logic  o_vld,
    output logic  o_hit
);

    logic  r_vld2;
    t_prod r_prod;
    t_prod n_prod;
    logic  r_vld3;
    logic  r_hit;
    logic  n_hit;

    always_comb begin
        n_prod.a1  = PROD_W'($signed(i_prep.ax1) * $signed(i_prep.dy));
        n_prod.a2  = PROD_W'($signed(i_prep.ax2) * $signed(i_prep.dy));
        n_prod.b1  = PROD_W'($signed(i_prep.by1) * $signed(i_prep.dx));
        n_prod.b2  = PROD_W'($signed(i_prep.by2) * $signed(i_prep.dx));
        n_prod.sep = i_prep.sep;
    end

    function automatic logic [CROSS_W-1:0] xsub(input logic [PROD_W-1:0] a,
                                                input logic [PROD_W-1:0] b);
        xsub = {a[PROD_W-1], a} - {b[PROD_W-1], b};
    endfunction

    always_comb begin
        logic [CROSS_W-1:0] c11, c12, c21, c22;
        logic               all_pos, all_neg;
        c11 = xsub(r_prod.a1, r_prod.b1);
        c12 = xsub(r_prod.a1, r_prod.b2);
        c21 = xsub(r_prod.a2, r_prod.b1);
        c22 = xsub(r_prod.a2, r_prod.b2);
        all_neg = c11[CROSS_W-1] && c12[CROSS_W-1] && c21[CROSS_W-1] && c22[CROSS_W-1];
        all_pos = !c11[CROSS_W-1] && (c11 != '0) && !c12[CROSS_W-1] && (c12 != '0) &&
                  !c21[CROSS_W-1] && (c21 != '0) && !c22[CROSS_W-1] && (c22 != '0);
        // all corners strictly on one side of the segment line: no contact
        n_hit = !(r_prod.sep || all_pos || all_neg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            r_vld2 <= i_vld;
            r_vld3 <= r_vld2;
        end
        r_prod <= n_prod;
        r_hit  <= n_hit;
    end

    assign o_vld = r_vld3;
    assign o_hit = r_vld3 & r_hit;

endmodule

// File: src/segment_rectangle_hit_test_top.sv
// Channel   Direction  Handshake                 Payload
// request   in         start && !busy            i_seg_*, i_box_* coordinates
// result    out        o_hit_valid (one cycle)   o_hit
//
// Three register stages: offsets and axis tests, four multipliers, sign check.
// A request is taken every cycle; its result strobes after the offset, product and hit registers.
// busy stays low: the pipeline never stalls, results are not held off.
// Synchronous active-low reset clears the valid bits only.
// Top level; depends on srht_pkg, srht_prep and srht_cross.
module segment_rectangle_hit_test_top
    import srht_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] i_seg_start_x,
    input  logic [COORD_BITS-1:0] i_seg_start_y,
    input  logic [COORD_BITS-1:0] i_seg_end_x,
    input  logic [COORD_BITS-1:0] i_seg_end_y,
    input  logic [COORD_BITS-1:0] i_box_first_x,
    input  logic [COORD_BITS-1:0] i_box_first_y,
    input  logic [COORD_BITS-1:0] i_box_second_x,
    input  logic [COORD_BITS-1:0] i_box_second_y,
    output logic                  o_hit_valid,
    output logic                  o_hit
);

    logic  s1_vld;
    t_prep s1_prep;
    logic  req;

    assign busy = 1'b0;
    assign req  = start && !busy;

    srht_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (req),
        .i_sx    (i_seg_start_x),
        .i_sy    (i_seg_start_y),
        .i_ex    (i_seg_end_x),
        .i_ey    (i_seg_end_y),
        .i_x1    (i_box_first_x),
        .i_y1    (i_box_first_y),
        .i_x2    (i_box_second_x),
        .i_y2    (i_box_second_y),
        .o_vld   (s1_vld),
        .o_prep  (s1_prep)
    );

    srht_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s1_vld),
        .i_prep  (s1_prep),
        .o_vld   (o_hit_valid),
        .o_hit   (o_hit)
    );

endmodule

// File: src/srht_checker.sv
// Port-level checks for the hit test pipeline, bound to the top level.
// Depends on segment_rectangle_hit_test_top.
module srht_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_hit_valid,
    input logic o_hit
);

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised on a pipeline that never stalls");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_hit_valid)
        else $error("accepted request produced no result three cycles later");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit_valid |-> $past(start, 3))
        else $error("result strobe without a matching request");

    a_hit_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_hit_valid |-> !o_hit)
        else $error("hit asserted outside a result strobe");

endmodule

bind segment_rectangle_hit_test_top srht_checker u_srht_checker (.*);
